// ===== sv/lru_pkg.sv =====
// Shared types and constants for the LRU replacement list.
package lru_pkg;

    localparam int FID_W = 6;
    localparam int CNT_W = 7;
    localparam int KIND_W = 2;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ERASE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_VICTIM = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;  // latch the request, start link reads
        logic unlink;   // take the target frame out of the chain
        logic link;     // place the target frame at the newest end
        logic emit;     // load the result register
    } lru_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic need_link;  // request is an insert that is carried out
        logic out_free;   // result register can take a beat
    } lru_stat_t;

endpackage

// ===== sv/lru_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lru_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/lru_ctrl.sv =====
// Controller state machine sequencing read, unlink, link and result load.
module lru_ctrl
    import lru_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  lru_stat_t stat,
    output lru_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_UNLINK = 2'd1;
    localparam logic [1:0] S_LINK   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_UNLINK;
                end
            end
            S_UNLINK:
            begin
                if (stat.need_link)
                begin
                    cmd.unlink = 1'b1;
                    state_next = S_LINK;
                end
                else if (stat.out_free)
                begin
                    cmd.unlink = 1'b1;
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_LINK:
            begin
                if (stat.out_free)
                begin
                    cmd.link   = 1'b1;
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/lru_dpath.sv =====
// Datapath: link RAMs, presence bits, list ends, count and result register.
module lru_dpath
    import lru_pkg::*;
#(
    parameter int FRAMES = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [KIND_W-1:0] kind,
    input  logic [FID_W-1:0]  frame_id,
    input  lru_cmd_t          cmd,
    output lru_stat_t         stat,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              ok,
    output logic [FID_W-1:0]  victim_frame,
    output logic [CNT_W-1:0]  entry_count
);

    // Only frames reachable through the frame number field are stored
    localparam int SLOTS = (FRAMES < (1 << FID_W)) ? FRAMES : (1 << FID_W);
    localparam int AW    = $clog2(SLOTS);
    localparam int PW    = 1 << AW;

    logic [PW-1:0]    present_reg;
    logic [AW-1:0]    newest_reg;
    logic [AW-1:0]    oldest_reg;
    logic [CNT_W-1:0] tracked_reg;

    // Request latched at acceptance
    logic [AW-1:0]    tgt_reg;
    logic             ins_reg;
    logic             rm_reg;
    logic             clr_reg;
    logic             vic_reg;
    logic             okf_reg;

    logic             out_valid_reg;
    logic             ok_reg;
    logic [FID_W-1:0] victim_reg;
    logic [CNT_W-1:0] count_reg;

    logic             in_range;
    logic             hit;
    logic             do_ins;
    logic             do_era;
    logic             do_vic;
    logic [AW-1:0]    tgt;
    logic [AW-1:0]    rd_addr;

    logic             mid_unlink;
    logic             tail_link;
    logic             prev_we;
    logic [AW-1:0]    prev_waddr;
    logic [AW-1:0]    prev_wdata;
    logic [AW-1:0]    prev_rdata;
    logic             next_we;
    logic [AW-1:0]    next_waddr;
    logic [AW-1:0]    next_wdata;
    logic [AW-1:0]    next_rdata;

    // Decode of the incoming beat
    assign in_range = (32'(frame_id) < SLOTS);
    assign hit      = present_reg[frame_id[AW-1:0]];
    assign do_ins   = (kind == KIND_INSERT) && in_range;
    assign do_era   = (kind == KIND_ERASE) && in_range && hit;
    assign do_vic   = (kind == KIND_VICTIM) && (tracked_reg != '0);
    assign tgt      = (kind == KIND_VICTIM) ? oldest_reg : frame_id[AW-1:0];

    // Read address follows the incoming beat at capture, then holds the target
    // so the link words stay put while the result register is busy
    assign rd_addr  = cmd.capture ? tgt : tgt_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            tgt_reg <= tgt;
            ins_reg <= do_ins;
            rm_reg  <= do_era || do_vic || (do_ins && hit);
            clr_reg <= do_era || do_vic;
            vic_reg <= do_vic;
            okf_reg <= do_ins || do_era || do_vic;
        end
    end

    // Link store writes: bypass neighbors on unlink, hook onto newest on link
    assign mid_unlink = cmd.unlink && rm_reg && (tracked_reg > 7'd1)
                        && (tgt_reg != newest_reg) && (tgt_reg != oldest_reg);
    assign tail_link  = cmd.link && (tracked_reg != '0);

    always_comb
    begin
        prev_we = mid_unlink || tail_link;
        next_we = mid_unlink || tail_link;
        if (mid_unlink)
        begin
            prev_waddr = next_rdata;
            prev_wdata = prev_rdata;
            next_waddr = prev_rdata;
            next_wdata = next_rdata;
        end
        else
        begin
            prev_waddr = newest_reg;
            prev_wdata = tgt_reg;
            next_waddr = tgt_reg;
            next_wdata = newest_reg;
        end
    end

    lru_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (rd_addr),
        .rdata (prev_rdata)
    );

    lru_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (rd_addr),
        .rdata (next_rdata)
    );

    // List ends, count and presence
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            newest_reg  <= '0;
            oldest_reg  <= '0;
            tracked_reg <= '0;
        end
        else if (cmd.unlink)
        begin
            if (rm_reg)
            begin
                tracked_reg <= tracked_reg - 7'd1;
                if (tracked_reg > 7'd1)
                begin
                    if (tgt_reg == newest_reg)
                    begin
                        newest_reg <= next_rdata;
                    end
                    else if (tgt_reg == oldest_reg)
                    begin
                        oldest_reg <= prev_rdata;
                    end
                end
            end
            if (clr_reg)
            begin
                present_reg[tgt_reg] <= 1'b0;
            end
        end
        else if (cmd.link)
        begin
            present_reg[tgt_reg] <= 1'b1;
            tracked_reg          <= tracked_reg + 7'd1;
            newest_reg           <= tgt_reg;
            if (tracked_reg == '0)
            begin
                oldest_reg <= tgt_reg;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (cmd.link)
            begin
                ok_reg     <= 1'b1;
                victim_reg <= '0;
                count_reg  <= tracked_reg + 7'd1;
            end
            else
            begin
                ok_reg     <= okf_reg;
                victim_reg <= vic_reg ? FID_W'(tgt_reg) : '0;
                count_reg  <= tracked_reg - CNT_W'(rm_reg);
            end
        end
    end

    assign stat.need_link = ins_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;
    assign out_valid      = out_valid_reg;
    assign ok             = ok_reg;
    assign victim_frame   = victim_reg;
    assign entry_count    = count_reg;

endmodule

// ===== sv/lru_replacer_unit.sv =====
// Top level of the LRU replacement list: controller plus datapath.
// Result register is loaded on leaving the unlink state for erase, victim and
// unknown kinds, or the link state for insert; either waits while it is full.
// Requests are taken one at a time: a new beat is accepted only back in idle, with
// the steps set by the registered read and single write port of each link RAM.
// Reset: asynchronous active low; list empty, count zero; link RAMs are not cleared.
module lru_replacer_unit
    import lru_pkg::*;
#(
    parameter int FRAMES = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [KIND_W-1:0] kind,
    input  logic [FID_W-1:0]  frame_id,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              ok,
    output logic [FID_W-1:0]  victim_frame,
    output logic [CNT_W-1:0]  entry_count
);

    lru_cmd_t  cmd;
    lru_stat_t stat;

    lru_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lru_dpath #(.FRAMES(FRAMES)) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .kind         (kind),
        .frame_id     (frame_id),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .ok           (ok),
        .victim_frame (victim_frame),
        .entry_count  (entry_count)
    );

endmodule

// ===== sv/lru_chk.sv =====
// Port-level checker for the LRU replacement list, bound to the top level.
module lru_chk
    import lru_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic [KIND_W-1:0] kind,
    input logic [FID_W-1:0]  frame_id,
    input logic              out_valid,
    input logic              out_ready,
    input logic              ok,
    input logic [FID_W-1:0]  victim_frame,
    input logic [CNT_W-1:0]  entry_count
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ok)
        && $stable(victim_frame) && $stable(entry_count))
        else $error("result beat changed while stalled");

    // One request at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on consecutive cycles");

    // A failed request never reports a victim
    a_fail_no_victim: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> victim_frame == '0)
        else $error("victim reported on failed request");

    // Count never exceeds the frame range
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entry_count <= 7'd64)
        else $error("entry count out of range");

endmodule

bind lru_replacer_unit lru_chk u_chk (.*);
